// File: hw/rtl/shadow_return_stack_core_macros.svh
`ifndef SHADOW_RETURN_STACK_CORE_MACROS_SVH
`define SHADOW_RETURN_STACK_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/srs_pkg.sv
package srs_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int REG_SLOTS   = 16;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int SP_AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LVL_W   = SP_AW;
	localparam int CNT_W   = $clog2(REG_SLOTS + 1);
	localparam int SLOT_W  = (REG_SLOTS > 1) ? $clog2(REG_SLOTS) : 1;

	localparam logic [63:0] FRAME_BYTES = 64'd8;

	typedef enum logic [1:0] {
		CMD_CALL    = 2'd0,
		CMD_RET     = 2'd1,
		CMD_SETJMP  = 2'd2,
		CMD_LONGJMP = 2'd3
	} srs_cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CALL_OVF   = 3'd1,
		ST_RET_UNF    = 3'd2,
		ST_SJ_FULL    = 3'd3,
		ST_SJ_EMPTY   = 3'd4,
		ST_LJ_NOMATCH = 3'd5
	} srs_status_t;

	typedef struct packed {
		srs_cmd_t    cmd;
		logic [63:0] pc_now;
		logic [63:0] call_target;
		logic [63:0] stack_ptr;
		logic [63:0] jmpbuf_key;
	} srs_req_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [63:0] next_stack_ptr;
		logic [6:0]  depth_after;
		srs_status_t status;
	} srs_rsp_t;

	typedef struct packed {
		logic [63:0]      key;
		logic [LVL_W-1:0] level;
		logic [63:0]      pc;
	} srs_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_STK_RD,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_PRUNE_RD,
		S_PRUNE_CHK,
		S_DONE
	} srs_state_t;

endpackage

// File: hw/rtl/shadow_return_stack_core.sv
// each accepted beat steps through the fsm: call and any rejected command go from exec to done
// setjmp reads the stack then writes the registration table; return reads the stack, then prunes
// longjmp searches slots up to the match, then prunes; with no match it searches every used slot
// one command in flight; set by the single read port of the stack and registration memories
// the next beat is taken the cycle after a result enters the output register
// reset clears depth, registration count, fsm and output valid; memories are not cleared
`include "shadow_return_stack_core_macros.svh"

module shadow_return_stack_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  srs_pkg::srs_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output srs_pkg::srs_rsp_t rsp
);
	import srs_pkg::*;

	srs_state_t state_q, state_d;

	logic [DEPTH_W-1:0] depth_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]  idx_q;
	logic               rsp_valid_q;
	srs_rsp_t           rsp_q;

	srs_req_t    item_q;
	logic [63:0] res_pc_q;
	logic [63:0] res_sp_q;
	srs_status_t res_st_q;

	logic [63:0] stk_mem [STACK_DEPTH];
	logic [63:0] stk_rdata_q;
	srs_entry_t  reg_mem [REG_SLOTS];
	srs_entry_t  reg_rdata_q;

	logic              stk_we, stk_re;
	logic [SP_AW-1:0]  stk_waddr, stk_raddr;
	logic              reg_we, reg_re;
	logic [SLOT_W-1:0] reg_waddr, reg_raddr;

	logic stk_full, stk_empty, tbl_full, tbl_empty;
	logic key_hit, prune_hit, search_last, out_free, accept;

	assign stk_full    = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign stk_empty   = (depth_q == '0);
	assign tbl_full    = (count_q == CNT_W'(REG_SLOTS));
	assign tbl_empty   = (count_q == '0);
	assign key_hit     = (reg_rdata_q.key == item_q.jmpbuf_key);
	assign prune_hit   = (depth_q < DEPTH_W'(reg_rdata_q.level));
	assign search_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign accept      = req_valid && req_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (item_q.cmd)
					CMD_CALL:    state_d = S_DONE;
					CMD_RET:     state_d = stk_empty ? S_DONE : S_STK_RD;
					CMD_SETJMP:  state_d = (tbl_full || stk_empty) ? S_DONE : S_STK_RD;
					CMD_LONGJMP: state_d = tbl_empty ? S_DONE : S_SRCH_RD;
					default:     state_d = S_DONE;
				endcase
			end
			S_STK_RD: begin
				state_d = (item_q.cmd == CMD_RET) ? S_PRUNE_RD : S_DONE;
			end
			S_SRCH_RD: begin
				state_d = S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				if (key_hit) state_d = S_PRUNE_RD;
				else if (search_last) state_d = S_DONE;
				else state_d = S_SRCH_RD;
			end
			S_PRUNE_RD: begin
				state_d = tbl_empty ? S_DONE : S_PRUNE_CHK;
			end
			S_PRUNE_CHK: begin
				state_d = prune_hit ? S_PRUNE_RD : S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_waddr = SP_AW'(depth_q);
		stk_raddr = SP_AW'(depth_q - DEPTH_W'(1));
		reg_we    = 1'b0;
		reg_re    = 1'b0;
		reg_waddr = SLOT_W'(count_q);
		reg_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_EXEC: begin
				case (item_q.cmd)
					CMD_CALL:   stk_we = !stk_full;
					CMD_RET:    stk_re = !stk_empty;
					CMD_SETJMP: stk_re = !tbl_full && !stk_empty;
					default:    stk_re = 1'b0;
				endcase
			end
			S_STK_RD: begin
				reg_we = (item_q.cmd == CMD_SETJMP);
			end
			S_SRCH_RD: begin
				reg_re = 1'b1;
			end
			S_PRUNE_RD: begin
				reg_re    = !tbl_empty;
				reg_raddr = SLOT_W'(count_q - CNT_W'(1));
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC && item_q.cmd == CMD_CALL && !stk_full)
				depth_q <= depth_q + DEPTH_W'(1);
			else if (state_q == S_EXEC && item_q.cmd == CMD_RET && !stk_empty)
				depth_q <= depth_q - DEPTH_W'(1);
			else if (state_q == S_SRCH_CHK && key_hit)
				depth_q <= DEPTH_W'(reg_rdata_q.level);
			if (reg_we)
				count_q <= count_q + CNT_W'(1);
			else if (state_q == S_PRUNE_CHK && prune_hit)
				count_q <= count_q - CNT_W'(1);
			if (state_q == S_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			res_pc_q <= req.pc_now;
			res_sp_q <= req.stack_ptr;
			res_st_q <= ST_OK;
			idx_q    <= '0;
		end
		case (state_q)
			S_EXEC: begin
				case (item_q.cmd)
					CMD_CALL: begin
						if (stk_full) begin
							res_st_q <= ST_CALL_OVF;
						end else begin
							res_pc_q <= item_q.call_target;
							res_sp_q <= item_q.stack_ptr - FRAME_BYTES;
						end
					end
					CMD_RET: begin
						if (stk_empty) res_st_q <= ST_RET_UNF;
						else res_sp_q <= item_q.stack_ptr + FRAME_BYTES;
					end
					CMD_SETJMP: begin
						if (tbl_full) res_st_q <= ST_SJ_FULL;
						else if (stk_empty) res_st_q <= ST_SJ_EMPTY;
					end
					default: begin
						if (tbl_empty) res_st_q <= ST_LJ_NOMATCH;
					end
				endcase
			end
			S_STK_RD: begin
				if (item_q.cmd == CMD_RET) res_pc_q <= stk_rdata_q;
			end
			S_SRCH_CHK: begin
				if (key_hit) res_pc_q <= reg_rdata_q.pc;
				else if (search_last) res_st_q <= ST_LJ_NOMATCH;
				idx_q <= idx_q + SLOT_W'(1);
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q.next_pc        <= res_pc_q;
					rsp_q.next_stack_ptr <= res_sp_q;
					rsp_q.depth_after    <= 7'(depth_q);
					rsp_q.status         <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	// return stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= item_q.pc_now;
		if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
	end

	// registration memory
	always_ff @(posedge clk) begin
		if (reg_we) begin
			reg_mem[reg_waddr].key   <= item_q.jmpbuf_key;
			reg_mem[reg_waddr].level <= LVL_W'(depth_q - DEPTH_W'(1));
			reg_mem[reg_waddr].pc    <= stk_rdata_q;
		end
		if (reg_re) reg_rdata_q <= reg_mem[reg_raddr];
	end

	`SRS_ASSERT_NOW(a_bounds, 1'b1, (depth_q <= DEPTH_W'(STACK_DEPTH)) && (count_q <= CNT_W'(REG_SLOTS)), "depth or registration count out of range")
	`SRS_ASSERT_NEXT(a_call_push, (state_q == S_EXEC) && (item_q.cmd == CMD_CALL) && !stk_full, depth_q == $past(depth_q) + DEPTH_W'(1), "call did not raise depth")
	`SRS_ASSERT_NEXT(a_prune_down, state_q == S_PRUNE_CHK, count_q <= $past(count_q), "prune raised registration count")
	`SRS_ASSERT_NEXT(a_accept_exec, accept, (state_q == S_EXEC) && !req_ready, "accepted beat not taken into execution")

endmodule

// File: tb/tb_top.sv
module tb_top;
	import srs_pkg::*;

	localparam int GEN = 0;
	localparam int CHK = 1;
	localparam int TRAP_TOTAL = 1120;
	localparam int HOLD_CYC = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYC = 100;
	localparam int PRINT_CAP = 40;

	typedef enum int {
		RCV_OPEN,
		RCV_BUSY,
		RCV_SPARSE,
		RCV_COMB
	} rcv_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	srs_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	srs_rsp_t rsp;

	// two copies of the shadow state: one steers stimulus, one predicts
	logic [63:0] mdl_stack [2][STACK_DEPTH];
	int unsigned mdl_depth [2];
	int unsigned mdl_count [2];
	logic [63:0] mdl_key [2][REG_SLOTS];
	int unsigned mdl_level [2][REG_SLOTS];
	logic [63:0] mdl_pc [2][REG_SLOTS];

	srs_req_t trap_q [$];
	srs_rsp_t outcome_q [$];
	logic [63:0] key_pool [6];

	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int press_at = 250;
	int mode_left = 0;
	rcv_mode_t rcv_mode = RCV_OPEN;
	int n_checked = 0;
	int err_cnt = 0;
	int idle_cyc = 0;
	srs_rsp_t want;

	shadow_return_stack_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic void drop_stale(input int m);
		while (mdl_count[m] > 0 && mdl_depth[m] < mdl_level[m][mdl_count[m] - 1])
			mdl_count[m]--;
	endfunction

	function automatic srs_rsp_t trap_outcome(input int m, input srs_req_t r);
		srs_rsp_t o;
		int hit;
		o.next_pc = r.pc_now;
		o.next_stack_ptr = r.stack_ptr;
		o.status = ST_OK;
		case (r.cmd)
			CMD_CALL: begin
				if (mdl_depth[m] >= STACK_DEPTH) begin
					o.status = ST_CALL_OVF;
				end else begin
					mdl_stack[m][mdl_depth[m]] = r.pc_now;
					mdl_depth[m]++;
					o.next_pc = r.call_target;
					o.next_stack_ptr = r.stack_ptr - FRAME_BYTES;
				end
			end
			CMD_RET: begin
				if (mdl_depth[m] == 0) begin
					o.status = ST_RET_UNF;
				end else begin
					mdl_depth[m]--;
					o.next_pc = mdl_stack[m][mdl_depth[m]];
					o.next_stack_ptr = r.stack_ptr + FRAME_BYTES;
					drop_stale(m);
				end
			end
			CMD_SETJMP: begin
				if (mdl_count[m] >= REG_SLOTS) begin
					o.status = ST_SJ_FULL;
				end else if (mdl_depth[m] == 0) begin
					o.status = ST_SJ_EMPTY;
				end else begin
					mdl_level[m][mdl_count[m]] = mdl_depth[m] - 1;
					mdl_pc[m][mdl_count[m]] = mdl_stack[m][mdl_depth[m] - 1];
					mdl_key[m][mdl_count[m]] = r.jmpbuf_key;
					mdl_count[m]++;
				end
			end
			CMD_LONGJMP: begin
				hit = -1;
				for (int i = 0; i < mdl_count[m]; i++)
					if (hit < 0 && mdl_key[m][i] == r.jmpbuf_key)
						hit = i;
				if (hit < 0) begin
					o.status = ST_LJ_NOMATCH;
				end else begin
					o.next_pc = mdl_pc[m][hit];
					mdl_depth[m] = mdl_level[m][hit];
					drop_stale(m);
				end
			end
		endcase
		o.depth_after = 7'(mdl_depth[m]);
		return o;
	endfunction

	// mostly keys that are live, so longjmps find their target
	function automatic logic [63:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60 && mdl_count[GEN] > 0)
			return mdl_key[GEN][$urandom_range(mdl_count[GEN] - 1)];
		if (roll < 90)
			return key_pool[$urandom_range(5)];
		return rnd64();
	endfunction

	task automatic add_trap(input srs_cmd_t c, input logic [63:0] pc, input logic [63:0] tgt,
			input logic [63:0] sp, input logic [63:0] key);
		srs_req_t r;
		srs_rsp_t ignored;
		r.cmd = c;
		r.pc_now = pc;
		r.call_target = tgt;
		r.stack_ptr = sp;
		r.jmpbuf_key = key;
		ignored = trap_outcome(GEN, r);
		trap_q.push_back(r);
	endtask

	task automatic add_rnd(input srs_cmd_t c, input logic [63:0] key);
		add_trap(c, rnd64(), rnd64(), rnd64(), key);
	endtask

	task automatic report_mismatch(input string fld, input logic [63:0] got,
			input logic [63:0] exp_val);
		err_cnt++;
		if (err_cnt <= PRINT_CAP)
			$display("mismatch %s at beat %0d: got %h exp %h", fld, n_checked, got, exp_val);
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_valid && req_ready)
				outcome_q.push_back(trap_outcome(CHK, req));
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (trap_q.size() > 0) begin
					req <= trap_q.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each beat, stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			mode_left <= 0;
			rcv_mode <= RCV_OPEN;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected beat", rsp.next_pc, '0);
				end else begin
					want = outcome_q.pop_front();
					if (rsp.next_pc !== want.next_pc)
						report_mismatch("next_pc", rsp.next_pc, want.next_pc);
					if (rsp.next_stack_ptr !== want.next_stack_ptr)
						report_mismatch("next_stack_ptr", rsp.next_stack_ptr,
							want.next_stack_ptr);
					if (rsp.depth_after !== want.depth_after)
						report_mismatch("depth_after", 64'(rsp.depth_after),
							64'(want.depth_after));
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
				end
				n_checked <= n_checked + 1;
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (n_checked >= press_at) begin
				// long hold-off so the core backs up into its input
				hold_left <= HOLD_CYC;
				press_at <= press_at + 450;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rcv_mode <= rcv_mode_t'($urandom_range(3));
					mode_left <= $urandom_range(20, 200);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (rcv_mode)
					RCV_OPEN: rsp_ready <= 1'b1;
					RCV_BUSY: rsp_ready <= ($urandom_range(9) < 7);
					RCV_SPARSE: rsp_ready <= ($urandom_range(9) < 3);
					default: rsp_ready <= (mode_left[2:0] != 3'd0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
	end

	initial begin
		int seg;
		int len;
		int roll;
		srs_cmd_t c;

		for (int i = 0; i < 6; i++)
			key_pool[i] = rnd64();
		for (int m = 0; m < 2; m++) begin
			mdl_depth[m] = 0;
			mdl_count[m] = 0;
		end

		// directed: empty-state errors and wrap of the stack pointer
		add_trap(CMD_RET, rnd64(), rnd64(), '1, rnd64());
		add_trap(CMD_SETJMP, rnd64(), rnd64(), rnd64(), '1);
		add_trap(CMD_LONGJMP, '0, '1, '0, '0);
		add_trap(CMD_CALL, '1, '0, '0, '1);
		add_trap(CMD_CALL, '0, '1, '1, '0);
		add_rnd(CMD_CALL, rnd64());
		// duplicate keys: the older registration wins, the newer one is pruned
		add_rnd(CMD_SETJMP, key_pool[0]);
		add_rnd(CMD_CALL, rnd64());
		add_rnd(CMD_SETJMP, key_pool[0]);
		add_rnd(CMD_LONGJMP, key_pool[0]);
		// pruning by return
		add_rnd(CMD_CALL, rnd64());
		add_rnd(CMD_CALL, rnd64());
		add_rnd(CMD_SETJMP, key_pool[1]);
		add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_LONGJMP, key_pool[1]);
		add_trap(CMD_RET, rnd64(), rnd64(), '1, rnd64());
		add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_LONGJMP, key_pool[0]);

		while (trap_q.size() < TRAP_TOTAL) begin
			seg = $urandom_range(99);
			if (seg < 8) begin
				// climb to the top and overflow
				while (mdl_depth[GEN] < STACK_DEPTH) begin
					if ($urandom_range(9) == 0 && mdl_depth[GEN] >= 2)
						add_rnd(CMD_SETJMP, pick_key());
					else
						add_rnd(CMD_CALL, rnd64());
				end
				repeat ($urandom_range(1, 3)) add_rnd(CMD_CALL, rnd64());
			end else if (seg < 14 && mdl_depth[GEN] >= 2) begin
				repeat ($urandom_range(8, 18)) add_rnd(CMD_SETJMP, pick_key());
			end else if (seg < 50) begin
				len = $urandom_range(4, 40);
				repeat (len) begin
					roll = $urandom_range(99);
					if (roll >= 80 && mdl_depth[GEN] >= 2)
						add_rnd(CMD_SETJMP, pick_key());
					else
						add_rnd(CMD_CALL, rnd64());
				end
			end else if (seg < 85) begin
				len = $urandom_range(4, 40);
				repeat (len) begin
					roll = $urandom_range(99);
					if (roll < 65)
						add_rnd(CMD_RET, rnd64());
					else if (roll < 90)
						add_rnd(CMD_LONGJMP, pick_key());
					else if (mdl_depth[GEN] >= 2)
						add_rnd(CMD_SETJMP, pick_key());
					else
						add_rnd(CMD_RET, rnd64());
				end
			end else begin
				len = $urandom_range(2, 10);
				repeat (len) begin
					c = srs_cmd_t'($urandom_range(3));
					// level-0 registrations never leave the table
					if (c == CMD_SETJMP && mdl_depth[GEN] == 1)
						c = CMD_CALL;
					add_rnd(c, pick_key());
				end
			end
		end

		// full table takes priority over empty stack
		while (mdl_depth[GEN] > 0)
			add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_CALL, rnd64());
		while (mdl_count[GEN] < REG_SLOTS)
			add_rnd(CMD_SETJMP, pick_key());
		add_rnd(CMD_RET, rnd64());
		add_rnd(CMD_SETJMP, pick_key());
		add_rnd(CMD_LONGJMP, pick_key());
		add_rnd(CMD_SETJMP, pick_key());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(trap_q.size() == 0 && !req_valid && outcome_q.size() == 0)
				&& idle_cyc < STALL_LIMIT)
			@(negedge clk);
		if (idle_cyc < STALL_LIMIT)
			repeat (DRAIN_CYC) @(negedge clk);

		if (err_cnt == 0 && idle_cyc < STALL_LIMIT && outcome_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/srs_pkg.sv
hw/rtl/shadow_return_stack_core.sv
tb/tb_top.sv
